// File: src/assert_macros.svh
// Assertion helpers used by the RTL file src/dss_scan.sv.
// Each macro samples on the rising edge of i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: src/dss_pkg.sv
`timescale 1ns / 1ps

package dss_pkg;

    localparam int MAX_DELIM_DEF  = 8;
    localparam int FIFO_DEPTH_DEF = 4;

    localparam int BYTE_W      = 8;
    localparam int DELIM_LEN_W = 4;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_BYTES  = 1'b1;

    localparam logic [DELIM_LEN_W-1:0] DELIM_LENGTH_RST = 4'd1;
    localparam logic [CFG_DATA_W-1:0]  DELIM_BYTES_RST  = 64'd44;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef logic [BYTE_W-1:0] t_byte;

    typedef struct packed {
        t_byte in_byte;
        logic  end_of_string;
    } t_in;

    typedef struct packed {
        t_byte out_byte;
        logic  kind;
        logic  last_of_run;
        logic  string_done;
    } t_out;

    typedef struct packed {
        logic valid;
        t_out data;
    } t_res;

endpackage

// File: src/dss_fifo.sv
`timescale 1ns / 1ps

module dss_fifo #(
    parameter int DEPTH = dss_pkg::FIFO_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  dss_pkg::t_res i_push,
    output logic         o_full,
    output logic         o_valid,
    input  logic         i_ready,
    output dss_pkg::t_out o_data
);
    import dss_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_out             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic             push;
    logic             pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign push    = i_push.valid & ~o_full;
    assign pop     = o_valid & i_ready;

    assign n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
    assign n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= n_wr;
            end
            if (pop) begin
                r_rd <= n_rd;
            end
            r_count <= r_count + CNT_W'(push) - CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push.data;
        end
    end

endmodule

// File: src/dss_scan.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dss_scan #(
    parameter int MAX_DELIM = dss_pkg::MAX_DELIM_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  dss_pkg::t_in                      i_in,
    input  logic                              i_cfg_we,
    input  logic [dss_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dss_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_full,
    output dss_pkg::t_res                     o_push
);
    import dss_pkg::*;

    localparam int CNT_W = $clog2(MAX_DELIM + 1);
    localparam int IDX_W = (MAX_DELIM > 1) ? $clog2(MAX_DELIM) : 1;

    logic [DELIM_LEN_W-1:0] r_len_cfg;
    logic [CFG_DATA_W-1:0]  r_delim;
    t_byte                  r_win [MAX_DELIM];
    logic [CNT_W-1:0]       r_count;
    logic                   r_work;
    logic                   r_eos;
    logic                   r_flush;

    logic [CNT_W-1:0]       len_eff;
    t_byte                  dl [MAX_DELIM];
    logic [MAX_DELIM-1:0]   eq;
    logic [MAX_DELIM-1:0]   len_mask;
    logic [MAX_DELIM-1:0]   cnt_mask;
    logic                   is_match;
    logic                   stable_now;

    logic                   step_en;
    logic                   emit;
    logic                   emit_end;
    logic [CNT_W-1:0]       drop;

    t_byte                  win_s [MAX_DELIM];
    logic [CNT_W-1:0]       count_s;
    logic [MAX_DELIM-1:0]   eq_s;
    logic [MAX_DELIM-1:0]   cnt_mask_s;
    logic                   stable_s;

    logic                   set_flush;
    logic                   done;
    logic                   last;
    logic                   sdone;
    logic                   accept;
    t_byte                  win_app [MAX_DELIM];

    always_comb begin
        if (r_len_cfg == '0) begin
            len_eff = CNT_W'(1);
        end else if (32'(r_len_cfg) > MAX_DELIM) begin
            len_eff = CNT_W'(MAX_DELIM);
        end else begin
            len_eff = CNT_W'(r_len_cfg);
        end
    end

    always_comb begin
        for (int k = 0; k < MAX_DELIM; k++) begin
            dl[k]       = r_delim[BYTE_W*k +: BYTE_W];
            eq[k]       = (r_win[k] == dl[k]);
            len_mask[k] = (CNT_W'(k) < len_eff);
            cnt_mask[k] = (CNT_W'(k) < r_count);
        end
        is_match   = (r_count >= len_eff) && (&(eq | ~len_mask));
        stable_now = (r_count == '0) || ((r_count < len_eff) && (&(eq | ~cnt_mask)));
    end

    // One scan step per cycle if step_en: front delimiter, held prefix, byte or flush.
    always_comb begin
        step_en  = r_work & ~i_full;
        emit     = 1'b0;
        emit_end = 1'b0;
        drop     = '0;
        if (step_en) begin
            if (r_flush) begin
                emit = 1'b1;
                if (r_count != '0) begin
                    drop = CNT_W'(1);
                end else begin
                    emit_end = 1'b1;
                end
            end else if (is_match) begin
                emit     = 1'b1;
                emit_end = 1'b1;
                drop     = len_eff;
            end else if (!stable_now) begin
                emit = 1'b1;
                drop = CNT_W'(1);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < MAX_DELIM; k++) begin
            win_s[k] = r_win[k];
            for (int j = 0; j < MAX_DELIM; j++) begin
                if ((k + j < MAX_DELIM) && (drop == CNT_W'(j))) begin
                    win_s[k] = r_win[IDX_W'(k + j)];
                end
            end
        end
        count_s = r_count - drop;
        for (int k = 0; k < MAX_DELIM; k++) begin
            eq_s[k]       = (win_s[k] == dl[k]);
            cnt_mask_s[k] = (CNT_W'(k) < count_s);
        end
        stable_s = (count_s == '0) || ((count_s < len_eff) && (&(eq_s | ~cnt_mask_s)));
    end

    always_comb begin
        set_flush = 1'b0;
        done      = 1'b0;
        last      = 1'b0;
        sdone     = 1'b0;
        if (step_en) begin
            if (r_flush) begin
                if (emit_end) begin
                    last  = 1'b1;
                    sdone = 1'b1;
                    done  = 1'b1;
                end
            end else if (!emit) begin
                if (r_eos) begin
                    set_flush = 1'b1;
                end else begin
                    done = 1'b1;
                end
            end else if (stable_s) begin
                if (!r_eos) begin
                    last = 1'b1;
                    done = 1'b1;
                end else if (emit_end && (count_s == '0)) begin
                    last  = 1'b1;
                    sdone = 1'b1;
                    done  = 1'b1;
                end else begin
                    set_flush = 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_push.valid            = emit;
        o_push.data.out_byte    = emit_end ? '0 : r_win[0];
        o_push.data.kind        = emit_end ? KIND_END : KIND_BYTE;
        o_push.data.last_of_run = last;
        o_push.data.string_done = sdone;
    end

    assign o_in_ready = ~r_work | done;
    assign accept     = i_in_valid & o_in_ready;

    always_comb begin
        for (int k = 0; k < MAX_DELIM; k++) begin
            win_app[k] = win_s[k];
        end
        if (accept) begin
            win_app[count_s[IDX_W-1:0]] = i_in.in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_cfg <= DELIM_LENGTH_RST;
            r_delim   <= DELIM_BYTES_RST;
            r_count   <= '0;
            r_work    <= 1'b0;
            r_eos     <= 1'b0;
            r_flush   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_DELIM_LENGTH: r_len_cfg <= i_cfg_data[DELIM_LEN_W-1:0];
                    CFG_DELIM_BYTES:  r_delim   <= i_cfg_data;
                    default:          r_delim   <= r_delim;
                endcase
            end
            r_count <= count_s + CNT_W'(accept);
            if (accept) begin
                r_work  <= 1'b1;
                r_eos   <= i_in.end_of_string;
                r_flush <= 1'b0;
            end else if (done) begin
                r_work  <= 1'b0;
                r_flush <= 1'b0;
            end else if (set_flush) begin
                r_flush <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_DELIM; k++) begin
            r_win[k] <= win_app[k];
        end
    end

    `ASSERT_IMPL(a_flush_needs_eos, r_flush, r_work && r_eos, "flush outside end of string")
    `ASSERT_IMPL(a_done_on_last_end, o_push.valid && o_push.data.string_done,
                 o_push.data.kind == KIND_END && o_push.data.last_of_run, "bad string end")
    `ASSERT_NEXT(a_accept_starts_work, accept, r_work, "accepted request not scanned")
    `ASSERT_IMPL(a_no_push_when_full, i_full, !o_push.valid, "push into full queue")

endmodule

// File: src/delimiter_stream_splitter.sv
`timescale 1ns / 1ps
// Splits a byte stream into tokens at a configurable delimiter of one to MAX_DELIM bytes.
// Input channel: i_in_valid / o_in_ready carry one byte and its end-of-string flag.
// Output channel: o_out_valid / i_out_ready carry token bytes and token-end markers, with
// last_of_run on the final result of each input request and string_done on the string's
// final token end.
// Configuration: i_cfg_we writes register i_cfg_idx (0 delimiter length, 1 delimiter
// bytes) from i_cfg_data; write only while the block is idle.
// The first result of a request is registered into the queue before it reaches the output.
// Throughput: one request per cycle while each request yields at most one result and the
// queue is not full; a request that yields several results, such as a broken prefix or
// an end-of-string flush, holds the input until its last result is pushed, at the single
// scan step per cycle; a pending end-of-string byte first sets the flush state.
// Results pass through a FIFO_DEPTH-entry queue, so a stalled receiver stops the scanner
// only once that queue is full; no result is dropped.
// Reset clears the pending window, the queue and the control state and restores a
// single comma as the delimiter.
module delimiter_stream_splitter #(
    parameter int MAX_DELIM  = dss_pkg::MAX_DELIM_DEF,
    parameter int FIFO_DEPTH = dss_pkg::FIFO_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  dss_pkg::t_in                   i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output dss_pkg::t_out                  o_out,
    input  logic                           i_cfg_we,
    input  logic [dss_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dss_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import dss_pkg::*;

    t_res push;
    logic full;

    dss_scan #(
        .MAX_DELIM(MAX_DELIM)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_full     (full),
        .o_push     (push)
    );

    dss_fifo #(
        .DEPTH(FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out)
    );

endmodule
